// ===== design/kcl_pkg.sv =====
`timescale 1ns / 1ps

package kcl_pkg;

	// Passcode length in characters.
	localparam int CODE_LEN = 6;
	localparam int CNT_W = $clog2(CODE_LEN + 1);

	// The passcode register holds this many characters; later positions read as zero.
	localparam int NUM_CHARS = 6;

	localparam int KEY_W = 8;
	localparam int CODE_W = NUM_CHARS * KEY_W;
	localparam int SERVO_W = 10;
	localparam int LIMIT_W = 8;
	localparam int DUTY_W = 8;
	localparam int MODE_W = 3;
	localparam int MSG_W = 3;
	localparam int CFG_IDX_W = 3;

	localparam logic [MSG_W-1:0] MSG_NONE = 3'd0;
	localparam logic [MSG_W-1:0] MSG_LOCKED = 3'd1;
	localparam logic [MSG_W-1:0] MSG_UNLOCKED = 3'd2;
	localparam logic [MSG_W-1:0] MSG_WRONG = 3'd3;
	localparam logic [MSG_W-1:0] MSG_LOCKING = 3'd4;
	localparam logic [MSG_W-1:0] MSG_CLEARED = 3'd5;

	localparam logic [MODE_W-1:0] MODE_LOCKED = 3'd1;
	localparam logic [MODE_W-1:0] MODE_UNLOCKED = 3'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_PASS_CODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_SERVO = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCK_SERVO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALARM_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ALARM_DUTY = 3'd4;

	localparam logic [CODE_W-1:0] PASS_CODE_RST = 48'd38707104198947;
	localparam logic [SERVO_W-1:0] UNLOCK_SERVO_RST = 10'd316;
	localparam logic [SERVO_W-1:0] LOCK_SERVO_RST = 10'd535;
	localparam logic [LIMIT_W-1:0] ALARM_LIMIT_RST = 8'd10;
	localparam logic [DUTY_W-1:0] ALARM_DUTY_RST = 8'd100;

	typedef struct packed {
		logic [MODE_W-1:0] lock_mode;
		logic key_matched;
		logic key_mismatch;
		logic servo_write;
		logic [SERVO_W-1:0] servo_value;
		logic [MSG_W-1:0] display_msg;
		logic unlocked;
		logic locked_any;
	} lock_res_t;

	typedef struct packed {
		logic alarm_active;
		logic [DUTY_W-1:0] speaker_level;
		logic alert_send;
	} alarm_res_t;

endpackage

// ===== design/kcl_lock.sv =====
`timescale 1ns / 1ps

module kcl_lock (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [kcl_pkg::KEY_W-1:0] key,
	input  logic [kcl_pkg::CODE_W-1:0] pass_code,
	input  logic [kcl_pkg::SERVO_W-1:0] unlock_servo_value,
	input  logic [kcl_pkg::SERVO_W-1:0] lock_servo_value,
	output kcl_pkg::lock_res_t res
);

	typedef enum logic [kcl_pkg::MODE_W-1:0] {
		ST_START = 3'd0,
		ST_LOCKED = 3'd1,
		ST_LOCKED_HELD = 3'd2,
		ST_UNLOCKED = 3'd3,
		ST_UNLOCKED_HELD = 3'd4,
		ST_LOCKING = 3'd5
	} phase_t;

	phase_t phase_q, phase_d;
	logic [kcl_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic [kcl_pkg::KEY_W-1:0] exp_char;
	logic cnt_below;
	logic key_fits;

	assign cnt_below = (cnt_q < kcl_pkg::CNT_W'(kcl_pkg::CODE_LEN));

	always_comb begin
		exp_char = '0;
		for (int i = 0; i < kcl_pkg::NUM_CHARS; i++) begin
			if (cnt_q == kcl_pkg::CNT_W'(i)) begin
				exp_char = pass_code[i*kcl_pkg::KEY_W +: kcl_pkg::KEY_W];
			end
		end
	end

	assign key_fits = cnt_below && (key == exp_char);

	always_comb begin
		phase_d = phase_q;
		cnt_d = cnt_q;
		res = '0;
		case (phase_q)
			ST_START: begin
				cnt_d = '0;
				phase_d = ST_UNLOCKED;
			end
			ST_LOCKED, ST_UNLOCKED: begin
				if (key != '0) begin
					phase_d = (phase_q == ST_LOCKED) ? ST_LOCKED_HELD : ST_UNLOCKED_HELD;
					if (key_fits) begin
						res.key_matched = 1'b1;
						cnt_d = cnt_q + 1'b1;
					end else begin
						res.key_mismatch = 1'b1;
						res.display_msg = (phase_q == ST_LOCKED) ? kcl_pkg::MSG_CLEARED
							: kcl_pkg::MSG_WRONG;
						cnt_d = '0;
					end
				end
			end
			ST_LOCKED_HELD: begin
				if (key == '0) begin
					if (cnt_below) begin
						phase_d = ST_LOCKED;
					end else begin
						res.servo_write = 1'b1;
						res.servo_value = unlock_servo_value;
						phase_d = ST_UNLOCKED;
						cnt_d = '0;
					end
				end
			end
			ST_UNLOCKED_HELD: begin
				if (key == '0) begin
					if (cnt_below) begin
						phase_d = ST_UNLOCKED;
					end else begin
						phase_d = ST_LOCKING;
						cnt_d = '0;
					end
				end
			end
			ST_LOCKING: begin
				if (cnt_below) begin
					res.display_msg = kcl_pkg::MSG_LOCKING;
					cnt_d = cnt_q + 1'b1;
					res.servo_write = 1'b1;
					res.servo_value = lock_servo_value;
				end else begin
					phase_d = ST_LOCKED;
					cnt_d = '0;
				end
			end
			default: begin
				phase_d = ST_START;
				cnt_d = '0;
			end
		endcase
		if (phase_d == ST_LOCKED) begin
			res.display_msg = kcl_pkg::MSG_LOCKED;
		end else if (phase_d == ST_UNLOCKED) begin
			res.display_msg = kcl_pkg::MSG_UNLOCKED;
		end
		res.lock_mode = phase_d;
		res.unlocked = (phase_d == ST_UNLOCKED);
		res.locked_any = (phase_d == ST_LOCKED) || (phase_d == ST_LOCKED_HELD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ST_START;
			cnt_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

// ===== design/kcl_alarm.sv =====
`timescale 1ns / 1ps

module kcl_alarm (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic motion,
	input  logic link_ready,
	input  logic unlocked,
	input  logic locked_any,
	input  logic [kcl_pkg::LIMIT_W-1:0] alarm_phase_limit,
	input  logic [kcl_pkg::DUTY_W-1:0] alarm_duty,
	output kcl_pkg::alarm_res_t res
);

	typedef enum logic [1:0] {
		AL_OFF = 2'd0,
		AL_SOUND = 2'd1,
		AL_SILENT = 2'd2
	} alarm_t;

	alarm_t al_q, al_d;
	logic [kcl_pkg::LIMIT_W-1:0] count_q, count_d;

	always_comb begin
		al_d = al_q;
		count_d = count_q;
		case (al_q)
			AL_SOUND, AL_SILENT: begin
				if (unlocked) begin
					al_d = AL_OFF;
				end else if (count_q <= alarm_phase_limit) begin
					count_d = count_q + 1'b1;
				end else begin
					al_d = (al_q == AL_SOUND) ? AL_SILENT : AL_SOUND;
					count_d = '0;
				end
			end
			default: begin
				al_d = (locked_any && motion) ? AL_SOUND : AL_OFF;
			end
		endcase
		res.alarm_active = (al_d == AL_SOUND);
		res.speaker_level = res.alarm_active ? alarm_duty : '0;
		res.alert_send = res.alarm_active && link_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			al_q <= AL_OFF;
			count_q <= '0;
		end else if (step) begin
			al_q <= al_d;
			count_q <= count_d;
		end
	end

endmodule

// ===== design/keypad_code_lock_with_alarm.sv =====
`timescale 1ns / 1ps

// Each accepted item's result is registered into the output register; the lock and alarm
// state update in the accept cycle. Throughput: one item per cycle when no result waits.
// A waiting result does not block input while the downstream side takes it in the same cycle.
// Reset (arst_n low, asynchronous) puts both machines in their start states and
// restores every configuration register to its default value.
module keypad_code_lock_with_alarm (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [kcl_pkg::KEY_W-1:0] key,
	input  logic motion,
	input  logic link_ready,
	output logic out_valid,
	input  logic out_ready,
	output logic [kcl_pkg::MODE_W-1:0] lock_mode,
	output logic key_matched,
	output logic key_mismatch,
	output logic servo_write,
	output logic [kcl_pkg::SERVO_W-1:0] servo_value,
	output logic [kcl_pkg::MSG_W-1:0] display_msg,
	output logic alarm_active,
	output logic [kcl_pkg::DUTY_W-1:0] speaker_level,
	output logic alert_send,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kcl_pkg::CODE_W-1:0] cfg_data
);

	logic [kcl_pkg::CODE_W-1:0] pass_code_q;
	logic [kcl_pkg::SERVO_W-1:0] unlock_servo_q;
	logic [kcl_pkg::SERVO_W-1:0] lock_servo_q;
	logic [kcl_pkg::LIMIT_W-1:0] alarm_limit_q;
	logic [kcl_pkg::DUTY_W-1:0] alarm_duty_q;

	logic step;
	logic out_valid_q;
	kcl_pkg::lock_res_t lock_res, lock_res_q;
	kcl_pkg::alarm_res_t alarm_res, alarm_res_q;

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid_q || out_ready;
	assign step = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_code_q <= kcl_pkg::PASS_CODE_RST;
			unlock_servo_q <= kcl_pkg::UNLOCK_SERVO_RST;
			lock_servo_q <= kcl_pkg::LOCK_SERVO_RST;
			alarm_limit_q <= kcl_pkg::ALARM_LIMIT_RST;
			alarm_duty_q <= kcl_pkg::ALARM_DUTY_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				kcl_pkg::CFG_PASS_CODE: pass_code_q <= cfg_data;
				kcl_pkg::CFG_UNLOCK_SERVO: unlock_servo_q <= cfg_data[kcl_pkg::SERVO_W-1:0];
				kcl_pkg::CFG_LOCK_SERVO: lock_servo_q <= cfg_data[kcl_pkg::SERVO_W-1:0];
				kcl_pkg::CFG_ALARM_LIMIT: alarm_limit_q <= cfg_data[kcl_pkg::LIMIT_W-1:0];
				kcl_pkg::CFG_ALARM_DUTY: alarm_duty_q <= cfg_data[kcl_pkg::DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	kcl_lock u_lock (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.key(key),
		.pass_code(pass_code_q),
		.unlock_servo_value(unlock_servo_q),
		.lock_servo_value(lock_servo_q),
		.res(lock_res)
	);

	kcl_alarm u_alarm (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.motion(motion),
		.link_ready(link_ready),
		.unlocked(lock_res.unlocked),
		.locked_any(lock_res.locked_any),
		.alarm_phase_limit(alarm_limit_q),
		.alarm_duty(alarm_duty_q),
		.res(alarm_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			lock_res_q <= lock_res;
			alarm_res_q <= alarm_res;
		end
	end

	assign out_valid = out_valid_q;
	assign lock_mode = lock_res_q.lock_mode;
	assign key_matched = lock_res_q.key_matched;
	assign key_mismatch = lock_res_q.key_mismatch;
	assign servo_write = lock_res_q.servo_write;
	assign servo_value = lock_res_q.servo_value;
	assign display_msg = lock_res_q.display_msg;
	assign alarm_active = alarm_res_q.alarm_active;
	assign speaker_level = alarm_res_q.speaker_level;
	assign alert_send = alarm_res_q.alert_send;

`ifndef NO_ASSERTIONS
	a_match_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(key_matched && key_mismatch))
		else $error("Key reported as both matched and mismatched.");

	a_servo_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !servo_write) |-> (servo_value == '0))
		else $error("Servo value driven without a servo command.");

	a_locked_msg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && lock_mode == kcl_pkg::MODE_LOCKED) |-> (display_msg == kcl_pkg::MSG_LOCKED))
		else $error("Locked state without the locked message.");

	a_unlocked_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && lock_mode == kcl_pkg::MODE_UNLOCKED) |-> !alarm_active)
		else $error("Alarm sounding in the unlocked state.");

	a_alert_sound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && alert_send) |-> alarm_active)
		else $error("Alert requested while the alarm is silent.");
`endif

endmodule

// ===== test/keypad_code_lock_with_alarm_tb.sv =====
`timescale 1ns / 1ps

module keypad_code_lock_with_alarm_tb;
	import kcl_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;

	localparam logic [MODE_W-1:0] LK_START = 3'd0;
	localparam logic [MODE_W-1:0] LK_LOCKED = MODE_LOCKED;
	localparam logic [MODE_W-1:0] LK_LOCKED_HELD = 3'd2;
	localparam logic [MODE_W-1:0] LK_UNLOCKED = MODE_UNLOCKED;
	localparam logic [MODE_W-1:0] LK_UNLOCKED_HELD = 3'd4;
	localparam logic [MODE_W-1:0] LK_LOCKING = 3'd5;

	localparam logic [1:0] SIREN_OFF = 2'd0;
	localparam logic [1:0] SIREN_SOUND = 2'd1;
	localparam logic [1:0] SIREN_SILENT = 2'd2;

	localparam int MOT_RANDOM = 0;
	localparam int MOT_HIGH = 1;
	localparam int MOT_LOW = 2;

	typedef struct packed {
		logic [MODE_W-1:0] lock_mode;
		logic key_matched;
		logic key_mismatch;
		logic servo_write;
		logic [SERVO_W-1:0] servo_value;
		logic [MSG_W-1:0] display_msg;
		logic alarm_active;
		logic [DUTY_W-1:0] speaker_level;
		logic alert_send;
	} tick_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [KEY_W-1:0] key;
	logic motion;
	logic link_ready;
	logic out_valid;
	logic out_ready;
	logic [MODE_W-1:0] lock_mode;
	logic key_matched;
	logic key_mismatch;
	logic servo_write;
	logic [SERVO_W-1:0] servo_value;
	logic [MSG_W-1:0] display_msg;
	logic alarm_active;
	logic [DUTY_W-1:0] speaker_level;
	logic alert_send;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CODE_W-1:0] cfg_data;

	keypad_code_lock_with_alarm dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.key(key),
		.motion(motion),
		.link_ready(link_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.lock_mode(lock_mode),
		.key_matched(key_matched),
		.key_mismatch(key_mismatch),
		.servo_write(servo_write),
		.servo_value(servo_value),
		.display_msg(display_msg),
		.alarm_active(alarm_active),
		.speaker_level(speaker_level),
		.alert_send(alert_send),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the lock state and its registers.
	logic [CODE_W-1:0] code_q;
	logic [SERVO_W-1:0] unlock_pos_q;
	logic [SERVO_W-1:0] lock_pos_q;
	logic [LIMIT_W-1:0] siren_limit_q;
	logic [DUTY_W-1:0] siren_duty_q;
	logic [MODE_W-1:0] phase_q;
	int digits_q;
	logic [1:0] siren_q;
	logic [7:0] siren_cnt_q;

	tick_result_t pending_results[$];
	int errors;
	int cycles;
	int items_sent;
	int snd_idle_pct;
	int rcv_idle_pct;
	int motion_mode;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [KEY_W-1:0] code_char(input int pos);
		if (pos >= NUM_CHARS)
			return '0;
		return code_q[KEY_W*pos +: KEY_W];
	endfunction

	function automatic tick_result_t predict_tick(input logic [KEY_W-1:0] k, input logic mot,
			input logic link);
		tick_result_t r;
		logic was_locked;
		r = '0;
		case (phase_q)
			LK_START: begin
				digits_q = 0;
				phase_q = LK_UNLOCKED;
			end
			LK_LOCKED, LK_UNLOCKED: begin
				if (k != '0) begin
					was_locked = (phase_q == LK_LOCKED);
					phase_q = was_locked ? LK_LOCKED_HELD : LK_UNLOCKED_HELD;
					if (digits_q < CODE_LEN && k == code_char(digits_q)) begin
						r.key_matched = 1'b1;
						digits_q++;
					end else begin
						r.key_mismatch = 1'b1;
						r.display_msg = was_locked ? MSG_CLEARED : MSG_WRONG;
						digits_q = 0;
					end
				end
			end
			LK_LOCKED_HELD: begin
				if (k == '0) begin
					if (digits_q < CODE_LEN) begin
						phase_q = LK_LOCKED;
					end else begin
						r.servo_write = 1'b1;
						r.servo_value = unlock_pos_q;
						phase_q = LK_UNLOCKED;
						digits_q = 0;
					end
				end
			end
			LK_UNLOCKED_HELD: begin
				if (k == '0) begin
					if (digits_q < CODE_LEN) begin
						phase_q = LK_UNLOCKED;
					end else begin
						phase_q = LK_LOCKING;
						digits_q = 0;
					end
				end
			end
			LK_LOCKING: begin
				if (digits_q < CODE_LEN) begin
					r.display_msg = MSG_LOCKING;
					digits_q++;
					r.servo_write = 1'b1;
					r.servo_value = lock_pos_q;
				end else begin
					phase_q = LK_LOCKED;
					digits_q = 0;
				end
			end
			default: begin
				phase_q = LK_START;
				digits_q = 0;
			end
		endcase
		if (phase_q == LK_LOCKED)
			r.display_msg = MSG_LOCKED;
		else if (phase_q == LK_UNLOCKED)
			r.display_msg = MSG_UNLOCKED;

		case (siren_q)
			SIREN_SOUND, SIREN_SILENT: begin
				if (phase_q == LK_UNLOCKED) begin
					siren_q = SIREN_OFF;
				end else if (siren_cnt_q <= siren_limit_q) begin
					siren_cnt_q = siren_cnt_q + 8'd1;
				end else begin
					siren_q = (siren_q == SIREN_SOUND) ? SIREN_SILENT : SIREN_SOUND;
					siren_cnt_q = '0;
				end
			end
			default: begin
				if ((phase_q == LK_LOCKED || phase_q == LK_LOCKED_HELD) && mot)
					siren_q = SIREN_SOUND;
				else
					siren_q = SIREN_OFF;
			end
		endcase
		if (siren_q == SIREN_SOUND) begin
			r.alarm_active = 1'b1;
			r.speaker_level = siren_duty_q;
			r.alert_send = link;
		end
		r.lock_mode = phase_q;
		return r;
	endfunction

	function automatic logic pick_motion();
		case (motion_mode)
			MOT_HIGH: return 1'b1;
			MOT_LOW: return 1'b0;
			default: return 1'($urandom_range(1));
		endcase
	endfunction

	task automatic send_tick(input logic [KEY_W-1:0] k, input logic mot, input logic link);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		key <= k;
		motion <= mot;
		link_ready <= link;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(predict_tick(k, mot, link));
		items_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_PASS_CODE: code_q = value;
			CFG_UNLOCK_SERVO: unlock_pos_q = value[SERVO_W-1:0];
			CFG_LOCK_SERVO: lock_pos_q = value[SERVO_W-1:0];
			CFG_ALARM_LIMIT: siren_limit_q = value[LIMIT_W-1:0];
			CFG_ALARM_DUTY: siren_duty_q = value[DUTY_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all_regs(input logic [CODE_W-1:0] code, input logic [SERVO_W-1:0] unlock_pos,
			input logic [SERVO_W-1:0] lock_pos, input logic [LIMIT_W-1:0] limit,
			input logic [DUTY_W-1:0] duty);
		write_reg(CFG_PASS_CODE, code);
		write_reg(CFG_UNLOCK_SERVO, CODE_W'(unlock_pos));
		write_reg(CFG_LOCK_SERVO, CODE_W'(lock_pos));
		write_reg(CFG_ALARM_LIMIT, CODE_W'(limit));
		write_reg(CFG_ALARM_DUTY, CODE_W'(duty));
	endtask

	// Presses every passcode character in turn (one altered at wrong_at), each followed by a release.
	task automatic enter_code(input int wrong_at, input int hold_max, input int gap_max);
		logic [KEY_W-1:0] c;
		for (int pos = 0; pos < CODE_LEN; pos++) begin
			c = code_char(pos);
			if (pos == wrong_at) begin
				c = c + 8'd1;
				if (c == '0)
					c = 8'd2;
			end
			repeat ($urandom_range(hold_max, 1))
				send_tick(c, pick_motion(), 1'($urandom_range(1)));
			repeat ($urandom_range(gap_max, 1))
				send_tick('0, pick_motion(), 1'($urandom_range(1)));
		end
	endtask

	task automatic run_sessions(input int count);
		int target;
		int pick;
		target = items_sent + count;
		while (items_sent < target) begin
			pick = $urandom_range(99);
			motion_mode = $urandom_range(2);
			if (pick < 60) begin
				enter_code(($urandom_range(3) == 0) ? int'($urandom_range(CODE_LEN - 1)) : -1,
					3, 2);
				repeat ($urandom_range(40))
					send_tick('0, pick_motion(), 1'($urandom_range(1)));
			end else if (pick < 80) begin
				repeat ($urandom_range(30, 1))
					send_tick('0, pick_motion(), 1'($urandom_range(1)));
			end else if (pick < 96) begin
				repeat ($urandom_range(10, 1))
					send_tick(KEY_W'($urandom_range(255)), 1'($urandom_range(1)),
						1'($urandom_range(1)));
			end else begin
				drain_results();
			end
		end
	endtask

	task automatic test_first_unlock_cycle();
		write_reg(CFG_ALARM_LIMIT, CODE_W'(1));
		write_reg(CFG_ALARM_DUTY, CODE_W'(255));
		write_reg(CFG_UNLOCK_SERVO, CODE_W'(1023));
		write_reg(CFG_LOCK_SERVO, CODE_W'(0));
		// The first item after reset unlocks regardless of the key.
		send_tick(8'hFF, 1'b1, 1'b1);
		motion_mode = MOT_HIGH;
		enter_code(-1, 1, 1);
		repeat (7) send_tick('0, 1'b1, 1'b0);
		send_tick(8'hFF, 1'b1, 1'b1);
		send_tick('0, 1'b1, 1'b1);
		send_tick('0, 1'b1, 1'b0);
		send_tick('0, 1'b0, 1'b1);
		// Unlocking while the alarm runs switches it off.
		enter_code(-1, 1, 1);
		send_tick(8'h01, 1'b0, 1'b0);
		send_tick('0, 1'b0, 1'b0);
	endtask

	task automatic test_random_sessions(input int phases, input int count);
		logic [CODE_W-1:0] code;
		logic [LIMIT_W-1:0] limit;
		repeat (phases) begin
			drain_results();
			for (int i = 0; i < NUM_CHARS; i++)
				code[KEY_W*i +: KEY_W] = KEY_W'($urandom_range(255, 1));
			if ($urandom_range(9) < 7)
				limit = LIMIT_W'($urandom_range(12, 1));
			else
				limit = LIMIT_W'($urandom_range(255, 1));
			write_all_regs(code, SERVO_W'($urandom_range(1023)), SERVO_W'($urandom_range(1023)),
				limit, DUTY_W'($urandom_range(255)));
			run_sessions(count);
		end
	endtask

	// With the largest limit the alarm count wraps and a phase never ends.
	task automatic test_alarm_count_wrap(input int count);
		drain_results();
		write_all_regs({CODE_W{1'b1}}, '0, {SERVO_W{1'b1}}, {LIMIT_W{1'b1}}, '0);
		run_sessions(count);
	endtask

	// An all-zero code can never be entered, so every key is a mismatch.
	task automatic test_blank_code(input int count);
		drain_results();
		write_all_regs('0, UNLOCK_SERVO_RST, LOCK_SERVO_RST, ALARM_LIMIT_RST, ALARM_DUTY_RST);
		run_sessions(count);
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= rcv_idle_pct);

	always @(posedge clk) begin : result_check
		tick_result_t got;
		tick_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {lock_mode, key_matched, key_mismatch, servo_write, servo_value, display_msg,
				alarm_active, speaker_level, alert_send};
			if (pending_results.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("unexpected result at cycle %0d: mode %0d", cycles, got.lock_mode);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					if (errors < MAX_REPORTS) begin
						$write("mismatch at cycle %0d: exp/got mode %0d/%0d match %b/%b ",
							cycles, want.lock_mode, got.lock_mode, want.key_matched,
							got.key_matched);
						$write("miss %b/%b servo %b %0d/%b %0d msg %0d/%0d alarm %b/%b ",
							want.key_mismatch, got.key_mismatch, want.servo_write,
							want.servo_value, got.servo_write, got.servo_value,
							want.display_msg, got.display_msg, want.alarm_active,
							got.alarm_active);
						$display("spk %0d/%0d alert %b/%b", want.speaker_level,
							got.speaker_level, want.alert_send, got.alert_send);
					end
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		key = '0;
		motion = 1'b0;
		link_ready = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		items_sent = 0;
		motion_mode = MOT_RANDOM;
		code_q = PASS_CODE_RST;
		unlock_pos_q = UNLOCK_SERVO_RST;
		lock_pos_q = LOCK_SERVO_RST;
		siren_limit_q = ALARM_LIMIT_RST;
		siren_duty_q = ALARM_DUTY_RST;
		phase_q = LK_START;
		digits_q = 0;
		siren_q = SIREN_OFF;
		siren_cnt_q = '0;
		snd_idle_pct = 22;
		rcv_idle_pct = 45;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_first_unlock_cycle();
		test_random_sessions(3, 150);
		snd_idle_pct = 45;
		rcv_idle_pct = 22;
		test_random_sessions(3, 150);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_alarm_count_wrap(200);
		test_blank_code(100);
		test_random_sessions(2, 120);
		drain_results();

		if (errors == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
